// ----- design/rlp_enc_pkg.sv -----
// Shared types and constants for the RLP item encoder.
package rlp_enc_pkg;

    typedef enum logic [1:0] {
        CMD_INT       = 2'd0,
        CMD_LIST      = 2'd1,
        CMD_STR_START = 2'd2,
        CMD_STR_BYTE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [63:0] value;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // One queued encoding job: a lead byte, then nbytes bytes taken from the
    // top of data, most significant byte first.
    typedef struct packed {
        logic [7:0]  lead;
        logic [63:0] data;
        logic [3:0]  nbytes;
    } job_t;

    localparam logic [7:0]  CODE_STRING_SHORT = 8'h80;
    localparam logic [7:0]  CODE_LIST_SHORT   = 8'hC0;
    localparam logic [7:0]  CODE_STRING_LONG  = 8'hB7;
    localparam logic [7:0]  CODE_LIST_LONG    = 8'hF7;
    localparam logic [63:0] SHORT_LIMIT       = 64'd56;

endpackage

// ----- design/rlp_enc_front.sv -----
// Front end: classifies each item into an encoding job and tracks the single-byte string flag.
module rlp_enc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  rlp_enc_pkg::in_item_t item,
    output logic                  push,
    output rlp_enc_pkg::job_t     job
);

    logic       pending_reg;
    logic       pending_next;
    logic [3:0] nb;
    logic [63:0] aligned;
    logic       emits;

    // Number of significant bytes in the value, 0 for zero.
    function automatic logic [3:0] byte_count(input logic [63:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[8*i +: 8] != 8'd0) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    assign nb      = byte_count(item.value);
    // Left-align the significant bytes so the back end shifts them out from the top.
    assign aligned = item.value << {(4'd8 - nb), 3'b000};

    always_comb
    begin
        job          = '0;
        job.data     = aligned;
        emits        = 1'b1;
        pending_next = 1'b0;
        case (item.command)
            rlp_enc_pkg::CMD_INT:
            begin
                if (item.value == 64'd0) begin
                    job.lead = rlp_enc_pkg::CODE_STRING_SHORT;
                end else if (item.value < 64'(rlp_enc_pkg::CODE_STRING_SHORT)) begin
                    job.lead = item.value[7:0];
                end else begin
                    job.lead   = rlp_enc_pkg::CODE_STRING_SHORT + 8'(nb);
                    job.nbytes = nb;
                end
            end
            rlp_enc_pkg::CMD_LIST:
            begin
                if (item.value < rlp_enc_pkg::SHORT_LIMIT) begin
                    job.lead = rlp_enc_pkg::CODE_LIST_SHORT + item.value[7:0];
                end else begin
                    job.lead   = rlp_enc_pkg::CODE_LIST_LONG + 8'(nb);
                    job.nbytes = nb;
                end
            end
            rlp_enc_pkg::CMD_STR_START:
            begin
                if (item.value == 64'd1) begin
                    emits        = 1'b0;
                    pending_next = 1'b1;
                end else if (item.value < rlp_enc_pkg::SHORT_LIMIT) begin
                    job.lead = rlp_enc_pkg::CODE_STRING_SHORT + item.value[7:0];
                end else begin
                    job.lead   = rlp_enc_pkg::CODE_STRING_LONG + 8'(nb);
                    job.nbytes = nb;
                end
            end
            rlp_enc_pkg::CMD_STR_BYTE:
            begin
                if (pending_reg && item.data_byte[7]) begin
                    job.lead   = rlp_enc_pkg::CODE_STRING_SHORT + 8'd1;
                    job.data   = {item.data_byte, 56'd0};
                    job.nbytes = 4'd1;
                end else begin
                    job.lead = item.data_byte;
                end
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
    end

    assign push = accept && emits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 1'b0;
        end else if (accept) begin
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- design/rlp_enc_queue.sv -----
// Short job queue between the front end and the byte serializer.
module rlp_enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rlp_enc_pkg::job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output rlp_enc_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlp_enc_pkg::job_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/rlp_enc_back.sv -----
// Back end: serializes each job into output bytes through a registered output stage.
module rlp_enc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  rlp_enc_pkg::job_t      head_job,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output rlp_enc_pkg::out_item_t result
);

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] sh_reg;
    logic        slot_free;

    assign slot_free = !out_valid_reg || !result_stall;
    assign pop       = head_valid && (cnt_reg == 4'd0) && slot_free;

    assign result_valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.run_last = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (slot_free) begin
            if (cnt_reg != 4'd0) begin
                out_byte_reg <= sh_reg[63:56];
                out_last_reg <= (cnt_reg == 4'd1);
                sh_reg       <= {sh_reg[55:0], 8'd0};
            end else if (head_valid) begin
                out_byte_reg <= head_job.lead;
                out_last_reg <= (head_job.nbytes == 4'd0);
                sh_reg       <= head_job.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
        end else if (slot_free) begin
            if (cnt_reg != 4'd0) begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_reg - 4'd1;
            end else if (head_valid) begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= head_job.nbytes;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/rlp_item_encoder_core.sv -----
// Top level of the RLP item encoder: front end, job queue and byte serializer.
//
// The block turns a stream of items into the RLP byte stream, one byte per
// result item, with run_last set on the final byte that each item causes.
// An item can encode a 64-bit integer, emit a list header, open a string of
// a given payload length, or pass one payload byte of a string. A string
// start of length one produces no bytes; the following string byte then
// comes out alone if it is below 0x80, or as 0x81 and the byte otherwise.
// The front end classifies each item in the cycle it is accepted and places
// an encoding job (a lead byte plus up to eight big-endian bytes) in a short
// queue; the back end drains jobs through a registered output stage at one
// byte per cycle while result_stall is low. Items whose encoding is a single
// byte can therefore follow each other in consecutive cycles. An item that
// expands to 1 + n bytes (n from 1 to 8) holds the serializer until all its
// bytes are out, so the sustained rate is set by the total output byte count;
// the queue of QUEUE_DEPTH jobs lets the input keep flowing while a long
// header drains, and item_stall rises only when that queue is full. A string
// start of length one places no job in the queue. There is no configuration
// and no clearing pass after reset.
module rlp_item_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  rlp_enc_pkg::in_item_t  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output rlp_enc_pkg::out_item_t result
);

    logic              accept;
    logic              push;
    rlp_enc_pkg::job_t push_job;
    logic              full;
    logic              pop;
    logic              head_valid;
    rlp_enc_pkg::job_t head_job;

    // The input is held off only while the job queue has no free entry.
    assign item_stall = full;
    assign accept     = item_valid && !full;

    rlp_enc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .job    (push_job)
    );

    rlp_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    rlp_enc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- design/rlp_enc_checker.sv -----
// Port-level checker for the RLP item encoder and its bind to the top level.
module rlp_enc_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input rlp_enc_pkg::out_item_t result
);

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // No result is shown while reset is applied.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // Bytes of one item leave without gaps: after a non-final byte the next is ready.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.run_last |=> result_valid)
        else $error("gap inside an item's byte run");

endmodule

bind rlp_item_encoder_core rlp_enc_checker u_rlp_enc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the RLP item encoder: stimulus, byte predictor and checker.
`timescale 1ns / 1ps

module tb;

    localparam int PHASE_ITEMS  = 45;      // accepted items per idling phase
    localparam int HOLD_START   = 30;      // accepted items before the long stall
    localparam int HOLD_CYCLES  = 80;      // length of the long receiver stall
    localparam int DRAIN_CYCLES = 30;      // quiet cycles watched after the last byte
    localparam int CYCLE_LIMIT  = 100000;  // hard stop for a hung run
    localparam int RANDOM_ITEMS = 80;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b1;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    rlp_enc_pkg::in_item_t  item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    rlp_enc_pkg::out_item_t result;

    rlp_enc_pkg::in_item_t  pending_items[$];  // items still to be offered to the block
    rlp_enc_pkg::out_item_t expected_bytes[$]; // encoded bytes predicted but not yet seen
    logic      one_byte_string_open = 1'b0;
    int        items_taken = 0;
    int        cycles = 0;
    int        err_count = 0;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_off = 1'b0;
    int        hold_left = 0;
    logic      hold_done = 1'b0;

    rlp_item_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    // Works out the bytes one accepted item produces and queues them.
    task automatic predict_encoding(input rlp_enc_pkg::in_item_t it);
        logic [7:0]  seq [9];
        int          n;
        int          nb;
        logic        prefixed;
        logic [7:0]  base;
        logic [63:0] v;
        n = 0;
        prefixed = 1'b0;
        base = '0;
        v = it.value;
        case (it.command)
            rlp_enc_pkg::CMD_INT:
            begin
                one_byte_string_open = 1'b0;
                if (it.value == 64'd0)
                begin
                    seq[n] = rlp_enc_pkg::CODE_STRING_SHORT;
                    n++;
                end
                else if (it.value < 64'(rlp_enc_pkg::CODE_STRING_SHORT))
                begin
                    seq[n] = it.value[7:0];
                    n++;
                end
                else
                begin
                    prefixed = 1'b1;
                    base = rlp_enc_pkg::CODE_STRING_SHORT;
                end
            end
            rlp_enc_pkg::CMD_LIST:
            begin
                one_byte_string_open = 1'b0;
                if (it.value < rlp_enc_pkg::SHORT_LIMIT)
                begin
                    seq[n] = rlp_enc_pkg::CODE_LIST_SHORT + it.value[7:0];
                    n++;
                end
                else
                begin
                    prefixed = 1'b1;
                    base = rlp_enc_pkg::CODE_LIST_LONG;
                end
            end
            rlp_enc_pkg::CMD_STR_START:
            begin
                // A one-byte string waits for its byte before anything is emitted.
                if (it.value == 64'd1)
                    one_byte_string_open = 1'b1;
                else
                begin
                    one_byte_string_open = 1'b0;
                    if (it.value < rlp_enc_pkg::SHORT_LIMIT)
                    begin
                        seq[n] = rlp_enc_pkg::CODE_STRING_SHORT + it.value[7:0];
                        n++;
                    end
                    else
                    begin
                        prefixed = 1'b1;
                        base = rlp_enc_pkg::CODE_STRING_LONG;
                    end
                end
            end
            default:
            begin
                if (one_byte_string_open && it.data_byte >= rlp_enc_pkg::CODE_STRING_SHORT)
                begin
                    seq[n] = rlp_enc_pkg::CODE_STRING_SHORT + 8'd1;
                    n++;
                end
                one_byte_string_open = 1'b0;
                seq[n] = it.data_byte;
                n++;
            end
        endcase
        if (prefixed)
        begin
            for (nb = 0; nb < 8 && (v >> (8 * nb)) != 64'd0; nb++)
                ;
            seq[n] = base + 8'(nb);
            n++;
            for (int i = nb; i > 0; i--)
            begin
                seq[n] = 8'(v >> (8 * (i - 1)));
                n++;
            end
        end
        for (int i = 0; i < n; i++)
            expected_bytes.push_back(
                rlp_enc_pkg::out_item_t'{out_byte: seq[i], run_last: (i == n - 1)});
    endtask

    task automatic add_item(input rlp_enc_pkg::cmd_t c, input logic [63:0] v,
                            input logic [7:0] b);
        pending_items.push_back(rlp_enc_pkg::in_item_t'{command: c, value: v, data_byte: b});
    endtask

    // Random value that needs at most nb bytes, top bits cleared.
    function automatic logic [63:0] random_value(input int nb);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (nb < 8)
            v = v & ((64'd1 << (8 * nb)) - 64'd1);
        return v;
    endfunction

    function automatic logic [63:0] random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return 64'd1;
        else if (pick < 70)
            return 64'($urandom_range(8));
        else if (pick < 90)
            return 64'($urandom_range(60, 9));
        return random_value($urandom_range(8, 1));
    endfunction

    task automatic build_directed();
        add_item(rlp_enc_pkg::CMD_INT, 64'd0, 8'h00);
        add_item(rlp_enc_pkg::CMD_INT, 64'd1, 8'hFF);
        add_item(rlp_enc_pkg::CMD_INT, 64'h7F, 8'h00);
        add_item(rlp_enc_pkg::CMD_INT, 64'h80, 8'h00);
        add_item(rlp_enc_pkg::CMD_INT, 64'h100, 8'h00);
        add_item(rlp_enc_pkg::CMD_INT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        add_item(rlp_enc_pkg::CMD_LIST, 64'd0, 8'h00);
        add_item(rlp_enc_pkg::CMD_LIST, 64'd55, 8'h00);
        add_item(rlp_enc_pkg::CMD_LIST, 64'd56, 8'h00);
        add_item(rlp_enc_pkg::CMD_LIST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd0, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd55, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd56, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        // One-byte strings: a low byte stands alone, a high byte gets a header.
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_BYTE, 64'd0, 8'h7F);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_BYTE, 64'd0, 8'h80);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        // Bytes with no one-byte string open pass through as they are.
        add_item(rlp_enc_pkg::CMD_STR_BYTE, 64'd0, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_BYTE, 64'd0, 8'hFF);
        // An open one-byte string is dropped by an integer or a list; a second one-byte string start keeps it open.
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_INT, 64'd5, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_LIST, 64'd3, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_START, 64'd1, 8'h00);
        add_item(rlp_enc_pkg::CMD_STR_BYTE, 64'd0, 8'h90);
    endtask

    task automatic build_random();
        int          count;
        int          kind;
        logic [63:0] len;
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            kind = $urandom_range(99);
            if (kind < 25)
            begin
                add_item(rlp_enc_pkg::CMD_INT, random_value($urandom_range(8)), 8'($urandom));
                count++;
            end
            else if (kind < 40)
            begin
                add_item(rlp_enc_pkg::CMD_LIST, random_length(), 8'($urandom));
                count++;
            end
            else if (kind < 85)
            begin
                // Well-formed string: header then, for lengths up to 60, its payload bytes, cut short at the end.
                len = random_length();
                add_item(rlp_enc_pkg::CMD_STR_START, len, 8'($urandom));
                count++;
                if (len <= 64'd60)
                begin
                    for (int i = 0; i < int'(len) && count < RANDOM_ITEMS; i++)
                    begin
                        add_item(rlp_enc_pkg::CMD_STR_BYTE, {$urandom, $urandom},
                                 8'($urandom));
                        count++;
                    end
                end
            end
            else
            begin
                add_item(rlp_enc_pkg::cmd_t'($urandom_range(3)),
                         random_value($urandom_range(8)), 8'($urandom));
                count++;
            end
        end
    endtask

    // Idling mix by phase: sender light and receiver heavy, then swapped, then none.
    always_comb
    begin
        if (items_taken < PHASE_ITEMS)
        begin
            send_idle_pct = 12;
            recv_stall_pct = 50;
        end
        else if (items_taken < 2 * PHASE_ITEMS)
        begin
            send_idle_pct = 50;
            recv_stall_pct = 12;
        end
        else
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
    end

    // Item driver: predicts on acceptance and offers the next item.
    always @(posedge clk)
    begin : item_driver
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_encoding(item);
                items_taken <= items_taken + 1;
            end
            if (!(item_valid && item_stall))
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // One long receiver stall so that the job queue fills and the input backs up.
    always @(posedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (!hold_done && items_taken >= HOLD_START)
            begin
                hold_off <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                if (hold_left == 1)
                    hold_off <= 1'b0;
            end
        end
    end

    // Byte monitor: checks every accepted byte against the oldest prediction.
    always @(posedge clk)
    begin : byte_monitor
        rlp_enc_pkg::out_item_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected byte %02h run_last %0b",
                                              result.out_byte, result.run_last));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                                  result.out_byte, want.out_byte));
                    if (result.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %0b, wanted %0b on byte %02h",
                                                  result.run_last, want.run_last,
                                                  want.out_byte));
                end
            end
            result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        build_directed();
        build_random();
        // Reset falls after time zero so the asynchronous reset sees a real edge.
        #1 rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d predicted bytes never arrived",
                                      expected_bytes.size()));
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- rlp_item_encoder_core.f -----
design/rlp_enc_pkg.sv
design/rlp_enc_front.sv
design/rlp_enc_queue.sv
design/rlp_enc_back.sv
design/rlp_item_encoder_core.sv
design/rlp_enc_checker.sv
bench/tb.sv
